@@ sv/mbss_pkg.sv @@
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared constants and types for the masked byte signature scan unit.
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int MAX_PATTERN  = 24;
  localparam int OFFSET_WIDTH = 32;
  localparam int LEN_WIDTH    = 5;
  localparam int WIN_AW       = $clog2(MAX_PATTERN);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 64;

  localparam logic [OFFSET_WIDTH-1:0] NEAR_LIMIT = OFFSET_WIDTH'(32'h20);
  localparam logic [OFFSET_WIDTH-1:0] FAR_LIMIT  = OFFSET_WIDTH'(32'h40000);

  localparam logic [CFG_AW-1:0] REG_PAT_LOW  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PAT_MID  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PAT_HIGH = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CARE     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LENGTH   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MODE     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_EXPECTED = 3'd6;
  localparam logic [CFG_AW-1:0] REG_BASE     = 3'd7;

  localparam logic MODE_FIRST   = 1'b0;
  localparam logic MODE_NEAREST = 1'b1;

  typedef struct packed {
    logic                    hit;
    logic                    last;
    logic [OFFSET_WIDTH-1:0] start;
  } scan_entry_t;

endpackage

@@ sv/masked_byte_signature_scan_unit.sv @@
// Result path: the entry of an image's last byte is written to the queue, then
//   popped by the back end and registered into the result outputs.
// Throughput: one byte per cycle while in_stall is low, set by the combinational window compare in
//   front and the one-entry-per-cycle best-match update in back.
// Reset: synchronous, active high; clears window, counters, queue and out_valid.
// ----------------------------------------------------------------------------
// masked_byte_signature_scan_unit
// Top level: configuration registers, front compare, entry queue, back end.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan_unit import mbss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              match_found,
  output logic [31:0]       match_offset,
  output logic [31:0]       match_distance,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic [63:0]          pattern_bytes_low, pattern_bytes_mid, pattern_bytes_high;
  logic [23:0]          care_mask;
  logic [LEN_WIDTH-1:0] pattern_length;
  logic                 search_mode;
  logic [31:0]          expected_address;
  logic [31:0]          image_base;

  logic        accept;
  logic        q_full, q_valid, q_pop;
  scan_entry_t front_entry, q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_mid  <= '0;
      pattern_bytes_high <= '0;
      care_mask          <= '0;
      pattern_length     <= '0;
      search_mode        <= MODE_FIRST;
      expected_address   <= '0;
      image_base         <= 32'h0040_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pattern_bytes_low  <= cfg_data;
        REG_PAT_MID:  pattern_bytes_mid  <= cfg_data;
        REG_PAT_HIGH: pattern_bytes_high <= cfg_data;
        REG_CARE:     care_mask          <= cfg_data[23:0];
        REG_LENGTH:   pattern_length     <= cfg_data[LEN_WIDTH-1:0];
        REG_MODE:     search_mode        <= cfg_data[0];
        REG_EXPECTED: expected_address   <= cfg_data[31:0];
        REG_BASE:     image_base         <= cfg_data[31:0];
        default:      ;
      endcase
    end
  end

  mbss_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .is_last        (is_last),
    .pattern        ({pattern_bytes_high, pattern_bytes_mid, pattern_bytes_low}),
    .care_mask      (care_mask),
    .pattern_length (pattern_length),
    .entry          (front_entry)
  );

  mbss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  mbss_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .search_mode      (search_mode),
    .expected_address (expected_address),
    .image_base       (image_base),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .match_found      (match_found),
    .match_offset     (match_offset),
    .match_distance   (match_distance)
  );

endmodule

@@ sv/mbss_front.sv @@
// ----------------------------------------------------------------------------
// mbss_front
// Byte window, saturating byte counter and masked compare; emits one
// classified entry per accepted byte.
// ----------------------------------------------------------------------------
module mbss_front import mbss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    is_last,
  input  logic [8*24-1:0]         pattern,
  input  logic [23:0]             care_mask,
  input  logic [LEN_WIDTH-1:0]    pattern_length,
  output scan_entry_t             entry
);

  logic [7:0]              win [MAX_PATTERN];
  logic [7:0]              win_next [MAX_PATTERN];
  logic [OFFSET_WIDTH-1:0] seen;
  logic [OFFSET_WIDTH-1:0] seen_next;
  logic                    counted;
  logic                    len_ok;
  logic                    bytes_match;
  logic [WIN_AW-1:0]       idx;

  always_comb begin
    win_next[0] = data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k] = win[k-1];
    end
  end

  assign counted   = (seen != {OFFSET_WIDTH{1'b1}});
  assign seen_next = counted ? seen + OFFSET_WIDTH'(1) : seen;
  assign len_ok    = (pattern_length != '0) &&
                     (pattern_length <= LEN_WIDTH'(MAX_PATTERN)) &&
                     (seen_next >= OFFSET_WIDTH'(pattern_length));

  always_comb begin
    bytes_match = 1'b1;
    idx = '0;
    for (int j = 0; j < 24 && j < MAX_PATTERN; j++) begin
      idx = WIN_AW'(pattern_length - LEN_WIDTH'(j + 1));
      if ((LEN_WIDTH'(j) < pattern_length) && care_mask[j]) begin
        if (pattern[8*j +: 8] != win_next[idx]) begin
          bytes_match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    entry.hit   = counted && len_ok && bytes_match;
    entry.last  = is_last;
    entry.start = seen_next - OFFSET_WIDTH'(pattern_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) win[k] <= '0;
    end else if (accept) begin
      if (is_last) begin
        seen <= '0;
        for (int k = 0; k < MAX_PATTERN; k++) win[k] <= '0;
      end else begin
        seen <= seen_next;
        for (int k = 0; k < MAX_PATTERN; k++) win[k] <= win_next[k];
      end
    end
  end

endmodule

@@ sv/mbss_queue.sv @@
// ----------------------------------------------------------------------------
// mbss_queue
// Short FIFO of classified entries between front and back.
// ----------------------------------------------------------------------------
module mbss_queue import mbss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  scan_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output scan_entry_t head
);

  scan_entry_t           mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/mbss_back.sv @@
// ----------------------------------------------------------------------------
// mbss_back
// Best-match tracking per mode and the registered result stage.
// ----------------------------------------------------------------------------
module mbss_back import mbss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  scan_entry_t             q_head,
  output logic                    q_pop,
  input  logic                    search_mode,
  input  logic [31:0]             expected_address,
  input  logic [31:0]             image_base,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    match_found,
  output logic [31:0]             match_offset,
  output logic [31:0]             match_distance
);

  logic [OFFSET_WIDTH-1:0] rva;
  logic [OFFSET_WIDTH-1:0] best_offset, best_offset_next;
  logic [OFFSET_WIDTH-1:0] best_distance, best_distance_next;
  logic                    have_match, have_match_next;
  logic                    settled, settled_next;
  logic [OFFSET_WIDTH-1:0] span;
  logic                    found;

  assign q_pop = q_valid && (!q_head.last || !out_valid || !out_stall);
  assign span  = (q_head.start > rva) ? q_head.start - rva : rva - q_head.start;

  always_comb begin
    best_offset_next   = best_offset;
    best_distance_next = best_distance;
    have_match_next    = have_match;
    settled_next       = settled;
    if (q_head.hit && !settled) begin
      if (search_mode == MODE_FIRST) begin
        if (!have_match) begin
          have_match_next  = 1'b1;
          best_offset_next = q_head.start;
          settled_next     = 1'b1;
        end
      end else if (span < best_distance) begin
        best_distance_next = span;
        best_offset_next   = q_head.start;
        have_match_next    = 1'b1;
        if (span < NEAR_LIMIT) settled_next = 1'b1;
      end
    end
    found = have_match_next &&
            ((search_mode == MODE_FIRST) || (best_distance_next <= FAR_LIMIT));
  end

  always_ff @(posedge clk) begin
    rva <= OFFSET_WIDTH'((expected_address >= image_base) ?
                         expected_address - image_base : expected_address);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_offset   <= '0;
      best_distance <= '1;
      have_match    <= 1'b0;
      settled       <= 1'b0;
    end else if (q_pop) begin
      if (q_head.last) begin
        best_offset   <= '0;
        best_distance <= '1;
        have_match    <= 1'b0;
        settled       <= 1'b0;
      end else begin
        best_offset   <= best_offset_next;
        best_distance <= best_distance_next;
        have_match    <= have_match_next;
        settled       <= settled_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_head.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      match_found    <= found;
      match_offset   <= found ? best_offset_next[31:0] : 32'd0;
      match_distance <= (found && (search_mode == MODE_NEAREST)) ?
                        best_distance_next[31:0] : 32'd0;
    end
  end

endmodule
